### hw/rtl/sps_pkg.sv
// Shared types and constants for the stable priority sorter.
package sps_pkg;

    localparam int MAX_JOBS_DEFAULT = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [5:0]  job_id;
        logic [15:0] burst_length;
        logic [7:0]  job_priority;
    } rec_t;

    typedef struct packed {
        rec_t rec;
        logic keep;
        logic last;
        logic ovf;
    } entry_t;

endpackage

### hw/rtl/sps_front.sv
// Front end: accepts job beats, counts the set and marks dropped records.
module sps_front #(
    parameter int MAX_JOBS = sps_pkg::MAX_JOBS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [5:0]     job_id,
    input  logic [15:0]    burst_length,
    input  logic [7:0]     job_priority,
    input  logic           set_end,
    input  logic           q_full,
    output logic           push,
    output sps_pkg::entry_t push_entry
);
    import sps_pkg::*;

    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          keep;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign keep     = cnt_reg < CW'(MAX_JOBS);

    always_comb
    begin
        push_entry.rec.job_id       = job_id;
        push_entry.rec.burst_length = burst_length;
        push_entry.rec.job_priority = job_priority;
        push_entry.keep             = keep;
        push_entry.last             = set_end;
        push_entry.ovf              = ovf_reg || !keep;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (push)
        begin
            if (set_end)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else if (keep)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

### hw/rtl/sps_queue.sv
// Short queue that decouples the front end from the sorting chain.
module sps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sps_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sps_pkg::entry_t pop_entry
);
    import sps_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign full      = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hw/rtl/sps_back.sv
// Back end: insertion cell chain that sorts a set and drains it in order.
module sps_back #(
    parameter int MAX_JOBS = sps_pkg::MAX_JOBS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  sps_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output sps_pkg::rec_t   out_rec,
    output logic            out_last,
    output logic            overflow
);
    import sps_pkg::*;

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                state_reg, state_next;
    logic                ovf_reg, ovf_next;
    logic [MAX_JOBS-1:0] valid_reg, valid_next;
    rec_t                cell_reg  [MAX_JOBS];
    rec_t                cell_next [MAX_JOBS];
    logic [MAX_JOBS-1:0] ins;
    logic                insert;
    logic                shift_out;

    assign q_pop     = (state_reg == ST_FILL) && q_not_empty;
    assign insert    = q_pop && q_entry.keep;
    assign out_valid = state_reg == ST_DRAIN;
    assign shift_out = out_valid && !out_stall;
    assign out_rec   = cell_reg[0];
    assign out_last  = !valid_reg[1];
    assign overflow  = ovf_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            ins[i] = !valid_reg[i] ||
                     (q_entry.rec.job_priority > cell_reg[i].job_priority);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            cell_next[i]  = cell_reg[i];
            valid_next[i] = valid_reg[i];
            if (shift_out)
            begin
                if (i < MAX_JOBS - 1)
                begin
                    cell_next[i]  = cell_reg[i + 1];
                    valid_next[i] = valid_reg[i + 1];
                end
                else
                begin
                    valid_next[i] = 1'b0;
                end
            end
            else if (insert)
            begin
                if (i == 0)
                begin
                    valid_next[i] = 1'b1;
                    if (ins[i])
                    begin
                        cell_next[i] = q_entry.rec;
                    end
                end
                else
                begin
                    valid_next[i] = valid_reg[i - 1];
                    if (ins[i - 1])
                    begin
                        cell_next[i] = cell_reg[i - 1];
                    end
                    else if (ins[i])
                    begin
                        cell_next[i] = q_entry.rec;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (q_pop && q_entry.last)
                begin
                    state_next = ST_DRAIN;
                    ovf_next   = q_entry.ovf;
                end
            end
            ST_DRAIN:
            begin
                if (shift_out && !valid_reg[1])
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            ovf_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

endmodule

### hw/rtl/stable_priority_sorter_unit.sv
// Top level of the stable priority sorter: front end, queue and sorting chain.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  job_id, burst_length, job_priority, set_end
//   out      out_valid/ out_stall out_job_id, out_burst_length, out_priority,
//                                 out_last, overflow
//
// The front end takes one beat per cycle into a four-entry queue.
// The chain inserts one queued record per cycle while it is filling.
// After the closing beat the run drains one record per cycle; the queue
// holds new beats meanwhile and stalls the input once it is full.
// Reset clears all control state at once; the chain needs no clearing pass.
// A stall on the output holds the current record and pauses the drain.
module stable_priority_sorter_unit #(
    parameter int MAX_JOBS = sps_pkg::MAX_JOBS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  job_id,
    input  logic [15:0] burst_length,
    input  logic [7:0]  job_priority,
    input  logic        set_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  out_job_id,
    output logic [15:0] out_burst_length,
    output logic [7:0]  out_priority,
    output logic        out_last,
    output logic        overflow
);
    import sps_pkg::*;

    logic   q_full;
    logic   push;
    entry_t push_entry;
    logic   q_pop;
    logic   q_not_empty;
    entry_t q_entry;
    rec_t   out_rec;

    sps_front #(
        .MAX_JOBS (MAX_JOBS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .job_id       (job_id),
        .burst_length (burst_length),
        .job_priority (job_priority),
        .set_end      (set_end),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    sps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_entry  (q_entry)
    );

    sps_back #(
        .MAX_JOBS (MAX_JOBS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_rec     (out_rec),
        .out_last    (out_last),
        .overflow    (overflow)
    );

    assign out_job_id       = out_rec.job_id;
    assign out_burst_length = out_rec.burst_length;
    assign out_priority     = out_rec.job_priority;

endmodule

### bench/stable_priority_sorter_unit_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the sorted runs of the priority sorter and compares every output beat.
module stable_priority_sorter_unit_checker #(
    parameter int MAX_JOBS = sps_pkg::MAX_JOBS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [5:0]  job_id,
    input  logic [15:0] burst_length,
    input  logic [7:0]  job_priority,
    input  logic        set_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  out_job_id,
    input  logic [15:0] out_burst_length,
    input  logic [7:0]  out_priority,
    input  logic        out_last,
    input  logic        overflow,
    output int          mismatches,
    output int          outstanding
);

    import sps_pkg::*;

    typedef struct {
        rec_t rec;
        logic last;
        logic ovf;
    } sorted_beat_t;

    rec_t         held_records[$];
    logic         dropped;
    sorted_beat_t sorted_beats[$];
    rec_t         ranked[$];
    rec_t         incoming;
    sorted_beat_t want;
    int           pos;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_records.delete();
            sorted_beats.delete();
            dropped     = 1'b0;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sorted_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: id=%0d burst=%0d prio=%0d last=%0d ovf=%0d",
                                 out_job_id, out_burst_length, out_priority, out_last,
                                 overflow);
                end
                else
                begin
                    want = sorted_beats.pop_front();
                    if (out_job_id !== want.rec.job_id
                        || out_burst_length !== want.rec.burst_length
                        || out_priority !== want.rec.job_priority
                        || out_last !== want.last || overflow !== want.ovf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch: expected id=%0d burst=%0d prio=%0d last=%0d ovf=%0d",
                                   want.rec.job_id, want.rec.burst_length,
                                   want.rec.job_priority, want.last, want.ovf);
                            $display(", got id=%0d burst=%0d prio=%0d last=%0d ovf=%0d",
                                     out_job_id, out_burst_length, out_priority, out_last,
                                     overflow);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                incoming.job_id       = job_id;
                incoming.burst_length = burst_length;
                incoming.job_priority = job_priority;
                if (held_records.size() < MAX_JOBS)
                    held_records.push_back(incoming);
                else
                    dropped = 1'b1;

                if (set_end)
                begin
                    // Stable insertion: a record goes behind every earlier one of equal priority.
                    ranked.delete();
                    foreach (held_records[i])
                    begin
                        pos = ranked.size();
                        while (pos > 0
                               && ranked[pos - 1].job_priority < held_records[i].job_priority)
                            pos--;
                        ranked.insert(pos, held_records[i]);
                    end
                    foreach (ranked[i])
                    begin
                        want.rec  = ranked[i];
                        want.last = (i == ranked.size() - 1);
                        want.ovf  = dropped;
                        sorted_beats.push_back(want);
                    end
                    held_records.delete();
                    dropped = 1'b0;
                end
            end

            outstanding = sorted_beats.size();
        end
    end

endmodule

### bench/stable_priority_sorter_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the priority sorter: clock, reset, job set stimulus and the verdict.
module stable_priority_sorter_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [5:0]  job_id = '0;
    logic [15:0] burst_length = '0;
    logic [7:0]  job_priority = '0;
    logic        set_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  out_job_id;
    logic [15:0] out_burst_length;
    logic [7:0]  out_priority;
    logic        out_last;
    logic        overflow;

    int mismatches;
    int outstanding;
    int idle_pct = 16;
    int stall_pct = 16;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    stable_priority_sorter_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .job_id           (job_id),
        .burst_length     (burst_length),
        .job_priority     (job_priority),
        .set_end          (set_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_job_id       (out_job_id),
        .out_burst_length (out_burst_length),
        .out_priority     (out_priority),
        .out_last         (out_last),
        .overflow         (overflow)
    );

    stable_priority_sorter_unit_checker run_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .job_id           (job_id),
        .burst_length     (burst_length),
        .job_priority     (job_priority),
        .set_end          (set_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_job_id       (out_job_id),
        .out_burst_length (out_burst_length),
        .out_priority     (out_priority),
        .out_last         (out_last),
        .overflow         (overflow),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stable_priority_sorter_unit test failed");
            $finish;
        end
    end

    task automatic send_job(input logic [5:0] id, input logic [15:0] burst,
                            input logic [7:0] prio, input logic closing);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        job_id       <= id;
        burst_length <= burst;
        job_priority <= prio;
        set_end      <= closing;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          set_no;
        int          set_size;
        int          prio_mode;
        logic [15:0] burst;
        logic [7:0]  prio;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_job(6'd63, 16'hFFFF, 8'hFF, 1'b1);
        send_job(6'd0, 16'h0000, 8'h00, 1'b1);
        send_job(6'd1, 16'd100, 8'd7, 1'b0);
        send_job(6'd2, 16'd200, 8'd7, 1'b0);
        send_job(6'd3, 16'd300, 8'd7, 1'b0);
        send_job(6'd4, 16'd400, 8'd7, 1'b1);
        for (int k = 1; k <= 5; k++)
            send_job(6'(10 + k), 16'(k * 1000), 8'(k), k == 5);
        send_job(6'd21, 16'h0001, 8'd10, 1'b0);
        send_job(6'd22, 16'h8000, 8'd200, 1'b0);
        send_job(6'd23, 16'h00FF, 8'd10, 1'b0);
        send_job(6'd24, 16'hFF00, 8'd255, 1'b0);
        send_job(6'd25, 16'h5555, 8'd200, 1'b1);
        send_job(6'd42, 16'hFFFF, 8'd0, 1'b0);
        send_job(6'd21, 16'h0000, 8'd255, 1'b0);
        send_job(6'd63, 16'hAAAA, 8'd0, 1'b1);

        sent   = 0;
        set_no = 0;
        while (sent < 420)
        begin
            if (set_no == 3)
                set_size = 32;
            else if (set_no == 6)
                set_size = 33;
            else if ($urandom_range(99) < 8)
                set_size = $urandom_range(40, 30);
            else
                set_size = $urandom_range(8, 1);
            prio_mode = $urandom_range(2);
            idle_pct  = (sent >= 150 && sent < 260) ? 0 : 16;
            stall_pct = idle_pct;
            for (int k = 0; k < set_size; k++)
            begin
                if ($urandom_range(9) == 0)
                    burst = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                else
                    burst = 16'($urandom());
                case (prio_mode)
                    0: prio = 8'($urandom_range(255));
                    1: prio = 8'($urandom_range(3));
                    default: prio = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
                send_job(6'($urandom_range(63)), burst, prio, k == set_size - 1);
                sent++;
            end
            set_no++;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("stable_priority_sorter_unit test passed");
        else
            $display("stable_priority_sorter_unit test failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_front.sv
hw/rtl/sps_queue.sv
hw/rtl/sps_back.sv
hw/rtl/stable_priority_sorter_unit.sv
bench/stable_priority_sorter_unit_checker.sv
bench/stable_priority_sorter_unit_tb.sv
